// File: src/mdb_pkg.sv
// Package for the MDB peripheral responder: payload structs, command codes,
// reply tables and the job descriptor passed from decoder to reply sequencer.
// No dependencies.
package mdb_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] command_word;
        logic [7:0] sub_command;
        logic [7:0] data_two;
        logic [7:0] data_three;
        logic [7:0] data_four;
        logic [7:0] data_five;
        logic [5:0] frame_length;
        logic [15:0] funds;
    } t_in_item;

    typedef struct packed {
        logic [8:0] reply_word;
        logic       last_word;
        logic [2:0] vend_event;
        logic       reader_enabled;
        logic [15:0] request_price;
        logic [15:0] item_number;
    } t_out_item;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_DISPLAY = 2'd1;
    localparam logic [1:0] KIND_BEGIN   = 2'd2;
    localparam logic [1:0] KIND_CANCEL  = 2'd3;

    localparam logic [1:0] REG_BUS_ENABLE = 2'd0;
    localparam logic [1:0] REG_CHANGER    = 2'd1;
    localparam logic [1:0] REG_READER     = 2'd2;

    localparam logic [8:0] ACK_WORD = 9'h100;
    localparam logic [8:0] NAK_WORD = 9'h1FF;

    localparam logic [8:0] CMD_CHG_RESET  = 9'h108;
    localparam logic [8:0] CMD_CHG_SETUP  = 9'h109;
    localparam logic [8:0] CMD_CHG_TUBES  = 9'h10A;
    localparam logic [8:0] CMD_CHG_POLL   = 9'h10B;
    localparam logic [8:0] CMD_CHG_TYPE   = 9'h10C;
    localparam logic [8:0] CMD_CHG_EXP    = 9'h10F;
    localparam logic [8:0] CMD_RDR_RESET  = 9'h110;
    localparam logic [8:0] CMD_RDR_SETUP  = 9'h111;
    localparam logic [8:0] CMD_RDR_POLL   = 9'h112;
    localparam logic [8:0] CMD_RDR_VEND   = 9'h113;
    localparam logic [8:0] CMD_RDR_READER = 9'h114;
    localparam logic [8:0] CMD_RDR_EXP    = 9'h115;
    localparam logic [8:0] CMD_RDR_X117   = 9'h117;

    // Reply programs played by the back end
    typedef enum logic [3:0] {
        SEQ_SHORT,      // up to four literal words, optional checksum
        SEQ_CHG_SETUP,
        SEQ_CHG_IDENT,
        SEQ_CHG_TUBES,
        SEQ_RDR_DISPLAY,
        SEQ_RDR_SETUP,
        SEQ_BEGIN,
        SEQ_X117
    } t_seq;

    typedef struct packed {
        t_seq        seq;
        logic [2:0]  nlit;       // literal words for SEQ_SHORT
        logic [35:0] lits;       // word 0 at [8:0]
        logic        add_sum;
        logic [2:0]  vend_event;
        logic        reader_enabled;
        logic [15:0] request_price;
        logic [15:0] item_number;
        logic [15:0] funds;
    } t_job;

    function automatic logic [7:0] chg_setup_rom(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0: v = 8'h02; 6'd1: v = 8'h11; 6'd2: v = 8'h52; 6'd3: v = 8'h05;
            6'd6: v = 8'h3E; 6'd7: v = 8'h01; 6'd8: v = 8'h02; 6'd9: v = 8'h0A;
            6'd10: v = 8'h14; 6'd11: v = 8'h14; 6'd12: v = 8'h64;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] chg_ident_rom(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0: v = 8'h4E; 6'd1: v = 8'h52; 6'd2: v = 8'h49; 6'd3: v = 8'h31;
            6'd4: v = 8'h30; 6'd5: v = 8'h31; 6'd6: v = 8'h30; 6'd7: v = 8'h34;
            6'd8: v = 8'h37; 6'd9: v = 8'h32; 6'd10: v = 8'h34; 6'd11: v = 8'h2D;
            6'd12: v = 8'h31; 6'd13: v = 8'h35; 6'd14: v = 8'h36; 6'd15: v = 8'h43;
            6'd16: v = 8'h32; 6'd17: v = 8'h20; 6'd18: v = 8'h76; 6'd19: v = 8'h36;
            6'd20: v = 8'h20; 6'd21: v = 8'h45; 6'd22: v = 8'h20; 6'd23: v = 8'h20;
            6'd24: v = 8'h33; 6'd25: v = 8'h37; 6'd26: v = 8'h37; 6'd27: v = 8'h09;
            6'd32: v = 8'h0F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] chg_tubes_rom(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd1: v = 8'h04; 6'd3: v = 8'h07; 6'd4: v = 8'h11; 6'd5: v = 8'h04;
            6'd6: v = 8'h1C; 6'd7: v = 8'h10;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rdr_display_rom(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0: v = 8'h02; 6'd1: v = 8'h80;
            6'd2: v = 8'h48; 6'd3: v = 8'h6F; 6'd4: v = 8'h6C; 6'd5: v = 8'h61;
            6'd6: v = 8'h20; 6'd7: v = 8'h44; 6'd8: v = 8'h61; 6'd9: v = 8'h6E;
            6'd10: v = 8'h69; 6'd11: v = 8'h65; 6'd12: v = 8'h6C;
            6'd18: v = 8'h48; 6'd19: v = 8'h6F; 6'd20: v = 8'h6C; 6'd21: v = 8'h61;
            6'd22: v = 8'h20; 6'd23: v = 8'h41; 6'd24: v = 8'h6C; 6'd25: v = 8'h76;
            6'd26: v = 8'h61; 6'd27: v = 8'h72; 6'd28: v = 8'h6F;
            default: v = 8'h21;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rdr_setup_rom(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0: v = 8'h01; 6'd1: v = 8'h02; 6'd3: v = 8'h56; 6'd4: v = 8'h01;
            6'd6: v = 8'h0F; 6'd7: v = 8'h03;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: src/mdb_peripheral_responder.sv
// MDB peripheral responder top level: decoder, job queue, reply sequencer
// and output register. Depends on mdb_pkg, mdb_decoder, mdb_job_queue,
// mdb_sequencer.
//
// Input channel: push/full. Each transaction is a decoded bus frame or a
// host event (display, begin session, cancel session). Host events and
// unanswered frames produce no output. The decoder takes one item per
// cycle whenever the two-entry job queue has room.
// Output channel: empty/pop. A reply runs as 1 to 35 words, one word per
// popped cycle, last_word marking the final word; data replies end with
// 0x100 OR the 8-bit sum of the words before it.
// The first reply word passes the job queue, the sequencer and the output register.
// Throughput: one reply word per cycle while the receiver pops, set by the
// sequencer, which takes a new job only when idle, after a reply's last word.
// Reset (synchronous, i_rst_n low): all three registers read 1, the reader
// reset is pending, the changer reports power-on, queues are emptied.
// When the receiver stalls, the word holds; the queue fills, then full rises.
module mdb_peripheral_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mdb_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output mdb_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic                i_cfg_data
);
    import mdb_pkg::*;

    logic r_bus_enable, r_changer_present, r_reader_present;
    logic  q_full, q_empty, seq_take, seq_valid, dec_valid;
    t_job  dec_job, q_job;
    t_out_item seq_item;
    logic  r_out_valid;
    t_out_item r_out;
    logic  seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_enable      <= 1'b1;
            r_changer_present <= 1'b1;
            r_reader_present  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUS_ENABLE: r_bus_enable      <= i_cfg_data;
                REG_CHANGER:    r_changer_present <= i_cfg_data;
                REG_READER:     r_reader_present  <= i_cfg_data;
                default:        r_bus_enable      <= r_bus_enable;
            endcase
        end
    end

    assign full = q_full;

    mdb_decoder u_dec (
        .i_clk, .i_rst_n,
        .i_valid(push && !q_full),
        .i_item(i_in_item),
        .i_bus_enable(r_bus_enable),
        .i_changer_present(r_changer_present),
        .i_reader_present(r_reader_present),
        .o_job_valid(dec_valid),
        .o_job(dec_job)
    );

    mdb_job_queue u_q (
        .i_clk, .i_rst_n,
        .i_push(dec_valid), .i_job(dec_job),
        .o_full(q_full), .o_empty(q_empty),
        .i_pop(seq_take), .o_job(q_job)
    );

    mdb_sequencer u_seq (
        .i_clk, .i_rst_n,
        .i_job_valid(!q_empty), .i_job(q_job),
        .o_job_take(seq_take),
        .o_valid(seq_valid), .o_item(seq_item),
        .i_ready(seq_ready)
    );

    // one-word output register
    assign seq_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ready) begin
            r_out_valid <= seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ready && seq_valid) begin
            r_out <= seq_item;
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> $stable(r_out)) else $error("output word changed");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("output not empty after reset");
    a_full_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !q_empty) else $error("full with empty queue");
endmodule

// File: src/mdb_decoder.sv
// Front end: classifies each transaction, updates the protocol state and
// emits one reply job per answered frame. Depends on mdb_pkg.
module mdb_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mdb_pkg::t_in_item i_item,
    input  logic             i_bus_enable,
    input  logic             i_changer_present,
    input  logic             i_reader_present,
    output logic             o_job_valid,
    output mdb_pkg::t_job    o_job
);
    import mdb_pkg::*;

    logic r_chg_power_on, r_chg_reset_pend, r_rdr_reset_pend;
    logic r_display_pend, r_begin_pend, r_cancel_pend;
    logic [15:0] r_funds, r_price, r_item;
    logic r_rdr_enable;

    logic n_chg_power_on, n_chg_reset_pend, n_rdr_reset_pend;
    logic n_display_pend, n_begin_pend, n_cancel_pend;
    logic [15:0] n_funds, n_price, n_item;
    logic n_rdr_enable;
    logic  emit;
    t_job  job;

    always_comb begin
        logic [8:0] cmd;
        logic [7:0] sub;
        logic [5:0] len;
        logic       blocked;
        cmd = i_item.command_word;
        sub = i_item.sub_command;
        len = i_item.frame_length;
        n_chg_power_on   = r_chg_power_on;
        n_chg_reset_pend = r_chg_reset_pend;
        n_rdr_reset_pend = r_rdr_reset_pend;
        n_display_pend   = r_display_pend;
        n_begin_pend     = r_begin_pend;
        n_cancel_pend    = r_cancel_pend;
        n_funds          = r_funds;
        n_price          = r_price;
        n_item           = r_item;
        n_rdr_enable     = r_rdr_enable;
        emit             = 1'b0;
        job              = '0;
        job.seq          = SEQ_SHORT;
        blocked = !i_bus_enable || len == 6'd0
            || (cmd inside {[9'h108:9'h10F]} && !i_changer_present)
            || (cmd inside {[9'h110:9'h117]} && !i_reader_present);
        case (i_item.kind)
            KIND_DISPLAY: n_display_pend = 1'b1;
            KIND_BEGIN: begin
                n_begin_pend = 1'b1;
                n_funds = i_item.funds;
            end
            KIND_CANCEL: n_cancel_pend = 1'b1;
            default: begin
                if (!blocked) begin
                    case (cmd)
                        CMD_CHG_RESET: if (len >= 6'd2) begin
                            emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            n_chg_reset_pend = 1'b1;
                        end
                        CMD_CHG_POLL: if (len >= 6'd2) begin
                            emit = 1'b1;
                            if (r_chg_power_on) begin
                                n_chg_power_on = 1'b0;
                                job.nlit = 3'd2; job.lits[17:0] = {CMD_CHG_POLL, 9'h00B};
                            end else if (r_chg_reset_pend) begin
                                n_chg_reset_pend = 1'b0;
                                job.nlit = 3'd2; job.lits[17:0] = {ACK_WORD, 9'h000};
                            end else begin
                                job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            end
                        end
                        CMD_CHG_SETUP: if (len >= 6'd2) begin
                            emit = 1'b1; job.seq = SEQ_CHG_SETUP;
                        end
                        CMD_CHG_EXP: if (len >= 6'd3) begin
                            if (sub == 8'h00) begin
                                emit = 1'b1; job.seq = SEQ_CHG_IDENT;
                            end else if (sub == 8'h01) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            end
                        end
                        CMD_CHG_TUBES: if (len >= 6'd2) begin
                            emit = 1'b1; job.seq = SEQ_CHG_TUBES;
                        end
                        CMD_CHG_TYPE: if (len >= 6'd6) begin
                            emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                        end
                        CMD_RDR_RESET: if (len >= 6'd2) begin
                            emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            n_rdr_reset_pend = 1'b1;
                        end
                        CMD_RDR_POLL: if (len >= 6'd2) begin
                            emit = 1'b1;
                            if (r_rdr_reset_pend) begin
                                n_rdr_reset_pend = 1'b0;
                                job.nlit = 3'd2; job.lits[17:0] = {ACK_WORD, 9'h000};
                            end else if (r_display_pend) begin
                                n_display_pend = 1'b0; job.seq = SEQ_RDR_DISPLAY;
                            end else if (r_begin_pend) begin
                                n_begin_pend = 1'b0; job.seq = SEQ_BEGIN;
                            end else if (r_cancel_pend) begin
                                n_cancel_pend = 1'b0;
                                job.nlit = 3'd1; job.lits[8:0] = 9'h004; job.add_sum = 1'b1;
                            end else begin
                                job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            end
                        end
                        CMD_RDR_SETUP: if (len >= 6'd7) begin
                            emit = 1'b1;
                            if (sub == 8'h00) begin
                                job.seq = SEQ_RDR_SETUP;
                            end else begin
                                job.nlit = 3'd1;
                                job.lits[8:0] = (sub == 8'h01) ? ACK_WORD : NAK_WORD;
                            end
                        end
                        CMD_RDR_VEND: begin
                            if (len >= 6'd7 && sub == 8'h00) begin
                                emit = 1'b1;
                                n_price = {i_item.data_two, i_item.data_three};
                                n_item  = {i_item.data_four, i_item.data_five};
                                job.nlit = 3'd3; job.add_sum = 1'b1;
                                job.lits[26:0] = {1'b0, i_item.data_three,
                                                  1'b0, i_item.data_two, 9'h005};
                            end else if (len >= 6'd3 && sub == 8'h01) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = 9'h006;
                                job.add_sum = 1'b1; job.vend_event = 3'd1;
                            end else if (len >= 6'd5 && sub == 8'h02) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                                job.vend_event = 3'd2;
                            end else if (len >= 6'd5 && sub == 8'h03) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                                job.vend_event = 3'd3;
                            end else if (len >= 6'd3 && sub == 8'h04) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = 9'h007;
                                job.add_sum = 1'b1; job.vend_event = 3'd4;
                            end
                        end
                        CMD_RDR_EXP: if (len >= 6'd3) begin
                            if (sub == 8'h00) begin
                                emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = 9'h00E;
                                job.add_sum = 1'b1;
                            end else if (sub == 8'h01) begin
                                emit = 1'b1; job.nlit = 3'd3; job.add_sum = 1'b1;
                                job.lits[26:0] = {9'h094, 9'h024, 9'h00F};
                            end
                        end
                        CMD_RDR_READER: if (len >= 6'd3) begin
                            emit = 1'b1; job.nlit = 3'd1; job.lits[8:0] = ACK_WORD;
                            n_rdr_enable = (sub != 8'h00);
                        end
                        CMD_RDR_X117: if (len >= 6'd32) begin
                            emit = 1'b1; job.seq = SEQ_X117;
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
        endcase
        job.reader_enabled = n_rdr_enable;
        job.request_price  = n_price;
        job.item_number    = n_item;
        job.funds          = r_funds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_power_on   <= 1'b1;
            r_chg_reset_pend <= 1'b0;
            r_rdr_reset_pend <= 1'b1;
            r_display_pend   <= 1'b0;
            r_begin_pend     <= 1'b0;
            r_cancel_pend    <= 1'b0;
            r_funds          <= '0;
            r_price          <= '0;
            r_item           <= '0;
            r_rdr_enable     <= 1'b0;
        end else if (i_valid) begin
            r_chg_power_on   <= n_chg_power_on;
            r_chg_reset_pend <= n_chg_reset_pend;
            r_rdr_reset_pend <= n_rdr_reset_pend;
            r_display_pend   <= n_display_pend;
            r_begin_pend     <= n_begin_pend;
            r_cancel_pend    <= n_cancel_pend;
            r_funds          <= n_funds;
            r_price          <= n_price;
            r_item           <= n_item;
            r_rdr_enable     <= n_rdr_enable;
        end
    end

    assign o_job_valid = i_valid && emit;
    assign o_job       = job;
endmodule

// File: src/mdb_job_queue.sv
// Two-entry queue of reply jobs between decoder and reply sequencer.
// Depends on mdb_pkg.
module mdb_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mdb_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output mdb_pkg::t_job o_job
);
    import mdb_pkg::*;

    t_job r_mem [2];
    logic r_wr, r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= !r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rd];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("job queue count overflow");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr == r_rd)
        else $error("job queue pointers disagree with count");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full) else $error("job queue lost an entry");
endmodule

// File: src/mdb_sequencer.sv
// Back end: plays one reply job as a run of words, one per cycle while i_ready
// is high, and appends the running checksum when the job has one. Depends on mdb_pkg.
module mdb_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  mdb_pkg::t_job     i_job,
    output logic              o_job_take,
    output logic              o_valid,
    output mdb_pkg::t_out_item o_item,
    input  logic              i_ready
);
    import mdb_pkg::*;

    typedef enum logic [0:0] { ST_IDLE, ST_RUN } t_state;

    t_state     r_state;
    t_job       r_job;
    logic [5:0] r_idx;
    logic [7:0] r_sum;

    logic [5:0] body_len;
    logic [8:0] body_word;
    logic       in_body;
    logic [8:0] word;
    logic       last;
    logic       has_sum;

    always_comb begin
        case (r_job.seq)
            SEQ_CHG_SETUP:   body_len = 6'd13;
            SEQ_CHG_IDENT:   body_len = 6'd33;
            SEQ_CHG_TUBES:   body_len = 6'd18;
            SEQ_RDR_DISPLAY: body_len = 6'd34;
            SEQ_RDR_SETUP:   body_len = 6'd8;
            SEQ_BEGIN:       body_len = 6'd10;
            SEQ_X117:        body_len = 6'd30;
            default:         body_len = {3'd0, r_job.nlit};
        endcase
        has_sum = (r_job.seq != SEQ_SHORT) || r_job.add_sum;
        case (r_job.seq)
            SEQ_CHG_SETUP:   body_word = {1'b0, chg_setup_rom(r_idx)};
            SEQ_CHG_IDENT:   body_word = {1'b0, chg_ident_rom(r_idx)};
            SEQ_CHG_TUBES:   body_word = {1'b0, chg_tubes_rom(r_idx)};
            SEQ_RDR_DISPLAY: body_word = {1'b0, rdr_display_rom(r_idx)};
            SEQ_RDR_SETUP:   body_word = {1'b0, rdr_setup_rom(r_idx)};
            SEQ_BEGIN: begin
                case (r_idx)
                    6'd0: body_word = 9'h003;
                    6'd1: body_word = {1'b0, r_job.funds[15:8]};
                    6'd2: body_word = {1'b0, r_job.funds[7:0]};
                    6'd3: body_word = 9'h001;
                    6'd4: body_word = 9'h002;
                    6'd5: body_word = 9'h003;
                    6'd6: body_word = 9'h004;
                    default: body_word = 9'h000;
                endcase
            end
            SEQ_X117: body_word = (r_idx == 6'd0) ? 9'h009 : 9'h000;
            default:  body_word = r_job.lits[r_idx[1:0]*9 +: 9];
        endcase
        in_body = r_idx < body_len;
        word = in_body ? body_word : {1'b1, r_sum};
        last = in_body ? (!has_sum && r_idx == body_len - 6'd1) : 1'b1;
    end

    assign o_valid    = r_state == ST_RUN;
    assign o_job_take = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        o_item.reply_word     = word;
        o_item.last_word      = last;
        o_item.vend_event     = r_job.vend_event;
        o_item.reader_enabled = r_job.reader_enabled;
        o_item.request_price  = r_job.request_price;
        o_item.item_number    = r_job.item_number;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (i_job_valid) begin
                    r_job   <= i_job;
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: if (i_ready) begin
                    // the low byte of every word played feeds the running checksum
                    r_sum <= r_sum + word[7:0];
                    r_idx <= r_idx + 6'd1;
                    if (last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_idx <= body_len) else $error("reply index overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_idx)) else $error("stalled word moved");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_state == ST_RUN) else $error("job taken but not started");
endmodule
